// ----- rtl/core/cbt_pkg.sv -----
// Shared widths, command and status types and the segment table of the CAN bit timing calculator.
package cbt_pkg;

   localparam int CLK_W   = 32;  // system clock register and dividend
   localparam int RATE_W  = 20;  // requested bit rate
   localparam int PDIV_W  = 4;   // peripheral divisor register
   localparam int SJW_W   = 2;   // sync jump width register
   localparam int DENOM_W = PDIV_W + RATE_W;  // divisor of the shared divider
   localparam int WORD_W  = 23;  // packed timing word
   localparam int BRP_W   = 10;  // prescaler field
   localparam int TSEG1_W = 4;
   localparam int TSEG2_W = 3;
   localparam int Q_W     = 5;   // quanta count per bit
   localparam int IDX_W   = 5;   // segment table index
   localparam int CNT_W   = $clog2(CLK_W + 1);
   localparam int IDX_CSR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int SJW_LSB   = 14;
   localparam int TSEG1_LSB = 16;
   localparam int TSEG2_LSB = 20;

   localparam logic [Q_W-1:0] Q_FIRST = Q_W'(24);
   localparam logic [Q_W-1:0] Q_LAST  = Q_W'(3);

   localparam int MAX_BITS_PER_BIT_TIME_DEF = 25;
   localparam int MIN_BITS_PER_BIT_TIME_DEF = 4;

   localparam logic [CLK_W-1:0]  SYS_CLK_RST = CLK_W'(96000000);
   localparam logic [PDIV_W-1:0] PDIV_RST    = PDIV_W'(1);
   localparam logic [SJW_W-1:0]  SJW_RST     = SJW_W'(1);

   // Register indexes on the configuration port
   localparam logic [IDX_CSR_W-1:0] CSR_SYS_CLK = IDX_CSR_W'(0);
   localparam logic [IDX_CSR_W-1:0] CSR_PDIV    = IDX_CSR_W'(1);
   localparam logic [IDX_CSR_W-1:0] CSR_SJW     = IDX_CSR_W'(2);

   // Operand choice for the shared divider
   typedef enum logic {
      DSEL_DENOM,
      DSEL_Q
   } cbt_dsel_type;

   typedef struct packed {
      logic         load;
      logic         mul;
      logic         div_go;
      cbt_dsel_type div_sel;
      logic         cap_w;
      logic         q_init;
      logic         q_dec;
      logic         set_hit;
      logic         set_miss;
   } cbt_cmd_type;

   typedef struct packed {
      logic div_done;
      logic denom_zero;
      logic w_zero;
      logic hit;
      logic q_last;
   } cbt_status_type;

   // TSEG2 and TSEG1 for a quanta count of index + 3, as {tseg2, tseg1}
   function automatic logic [TSEG2_W+TSEG1_W-1:0] seg_lookup(input logic [IDX_W-1:0] idx);
      logic [TSEG2_W+TSEG1_W-1:0] seg;
      case (idx)
         5'd0:    seg = {3'h0, 4'h0};
         5'd1:    seg = {3'h0, 4'h1};
         5'd2:    seg = {3'h0, 4'h2};
         5'd3:    seg = {3'h0, 4'h3};
         5'd4:    seg = {3'h1, 4'h3};
         5'd5:    seg = {3'h1, 4'h4};
         5'd6:    seg = {3'h1, 4'h5};
         5'd7:    seg = {3'h1, 4'h6};
         5'd8:    seg = {3'h2, 4'h6};
         5'd9:    seg = {3'h2, 4'h7};
         5'd10:   seg = {3'h2, 4'h8};
         5'd11:   seg = {3'h2, 4'h9};
         5'd12:   seg = {3'h3, 4'h9};
         5'd13:   seg = {3'h3, 4'hA};
         5'd14:   seg = {3'h3, 4'hB};
         5'd15:   seg = {3'h3, 4'hC};
         5'd16:   seg = {3'h3, 4'hD};
         5'd17:   seg = {3'h4, 4'hD};
         5'd18:   seg = {3'h4, 4'hE};
         5'd19:   seg = {3'h4, 4'hF};
         5'd20:   seg = {3'h5, 4'hF};
         5'd21:   seg = {3'h6, 4'hF};
         5'd22:   seg = {3'h7, 4'hF};
         default: seg = '0;
      endcase
      return seg;
   endfunction

endpackage

// ----- rtl/core/cbt_divider.sv -----
// Bit-serial restoring divider shared by every division of the calculator.
module cbt_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [cbt_pkg::CLK_W-1:0]    dividend,
   input  logic [cbt_pkg::DENOM_W-1:0]  divisor,
   output logic                         busy,
   output logic                         done,
   output logic [cbt_pkg::CLK_W-1:0]    quotient,
   output logic [cbt_pkg::DENOM_W-1:0]  remainder
);
   import cbt_pkg::*;

   logic [CLK_W-1:0]   quo_ff, quo_in;
   logic [DENOM_W-1:0] rem_ff, rem_in;
   logic [DENOM_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [DENOM_W:0]   trial;
   logic [DENOM_W+1:0] diff;
   logic               ge;

   // One quotient bit per cycle: shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[CLK_W-1]};
      diff  = {1'b0, trial} - {2'b00, dvs_ff};
      ge    = ~diff[DENOM_W+1];

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(CLK_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[CLK_W-2:0], ge};
         rem_in = ge ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/cbt_datapath.sv -----
// Datapath: configuration registers, clock ratio, search bounds and the quanta scan.
module cbt_datapath #(
   parameter int MAX_BITS_PER_BIT_TIME = cbt_pkg::MAX_BITS_PER_BIT_TIME_DEF,
   parameter int MIN_BITS_PER_BIT_TIME = cbt_pkg::MIN_BITS_PER_BIT_TIME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [cbt_pkg::IDX_CSR_W-1:0]   csr_index,
   input  logic [cbt_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic [cbt_pkg::RATE_W-1:0]      req_bit_rate_hz,
   input  cbt_pkg::cbt_cmd_type            cmd,
   output cbt_pkg::cbt_status_type         status,
   output logic                            rsp_found,
   output logic [cbt_pkg::WORD_W-1:0]      rsp_timing_word
);
   import cbt_pkg::*;

   logic [CLK_W-1:0]   sys_clk_ff;
   logic [PDIV_W-1:0]  pdiv_ff;
   logic [SJW_W-1:0]   sjw_ff;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [DENOM_W-1:0] denom_ff, denom_in;
   logic [CLK_W-1:0]   w_ff, w_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic               found_ff, found_in;
   logic [WORD_W-1:0]  word_ff, word_in;

   logic [CLK_W-1:0]   div_dividend;
   logic [DENOM_W-1:0] div_divisor;
   logic               div_busy;
   logic               div_done;
   logic [CLK_W-1:0]   div_quo;
   logic [DENOM_W-1:0] div_rem;

   logic [CLK_W-1:0]   presc;
   logic [IDX_W-1:0]   seg_idx;
   logic [TSEG2_W+TSEG1_W-1:0] seg;
   logic [CLK_W+Q_W-1:0] w_wide;
   logic [CLK_W+Q_W-1:0] quo_max;
   logic [CLK_W+Q_W-1:0] quo_min;

   // Hold configuration; writes to an unused index are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         sys_clk_ff <= SYS_CLK_RST;
         pdiv_ff    <= PDIV_RST;
         sjw_ff     <= SJW_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SYS_CLK: sys_clk_ff <= csr_write_data;
            CSR_PDIV:    pdiv_ff    <= csr_write_data[PDIV_W-1:0];
            CSR_SJW:     sjw_ff     <= csr_write_data[SJW_W-1:0];
            default:     ;
         endcase
      end
   end

   // Select divider operands
   always_comb begin
      div_dividend = (cmd.div_sel == DSEL_DENOM) ? sys_clk_ff : w_ff;
      case (cmd.div_sel)
         DSEL_DENOM: div_divisor = denom_ff;
         DSEL_Q:     div_divisor = DENOM_W'(q_ff);
         default:    div_divisor = denom_ff;
      endcase
   end

   cbt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Candidate prescaler and its segment split for the current quanta count
   always_comb begin
      presc   = div_quo - CLK_W'(1);
      seg_idx = IDX_W'(q_ff - Q_LAST);
      seg     = seg_lookup(seg_idx);
   end

   // Bound the prescaler without dividing: quo-1 >= w/MAX exactly when quo*MAX > w,
   // and quo-1 < w/MIN exactly when quo*MIN <= w
   always_comb begin
      w_wide  = (CLK_W+Q_W)'(w_ff);
      quo_max = (CLK_W+Q_W)'(div_quo) * (CLK_W+Q_W)'(MAX_BITS_PER_BIT_TIME);
      quo_min = (CLK_W+Q_W)'(div_quo) * (CLK_W+Q_W)'(MIN_BITS_PER_BIT_TIME);
   end

   // Advance the working registers on controller commands
   always_comb begin
      rate_in  = cmd.load      ? req_bit_rate_hz : rate_ff;
      denom_in = cmd.mul       ? ({{RATE_W{1'b0}}, pdiv_ff} * {{PDIV_W{1'b0}}, rate_ff})
                               : denom_ff;
      w_in     = cmd.cap_w     ? div_quo : w_ff;
      q_in     = q_ff;
      if (cmd.q_init) begin
         q_in = Q_FIRST;
      end else if (cmd.q_dec) begin
         q_in = q_ff - Q_W'(1);
      end
      found_in = found_ff;
      word_in  = word_ff;
      if (cmd.set_hit) begin
         found_in = 1'b1;
         word_in  = WORD_W'(presc[BRP_W-1:0])
                  | (WORD_W'(sjw_ff) << SJW_LSB)
                  | (WORD_W'(seg[TSEG1_W-1:0]) << TSEG1_LSB)
                  | (WORD_W'(seg[TSEG2_W+TSEG1_W-1:TSEG1_W]) << TSEG2_LSB);
      end else if (cmd.set_miss) begin
         found_in = 1'b0;
         word_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff  <= rate_in;
      denom_ff <= denom_in;
      w_ff     <= w_in;
      q_ff     <= q_in;
      if (reset) begin
         found_ff <= 1'b0;
         word_ff  <= '0;
      end else begin
         found_ff <= found_in;
         word_ff  <= word_in;
      end
   end

   // Report to the controller
   always_comb begin
      status.div_done   = div_done;
      status.denom_zero = (denom_ff == '0);
      status.w_zero     = (w_ff == '0);
      status.hit        = (div_rem == '0) && (div_quo != '0)
                        && (w_wide < quo_max) && (quo_min <= w_wide);
      status.q_last     = (q_ff == Q_LAST);
   end

   assign rsp_found       = found_ff;
   assign rsp_timing_word = word_ff;

   // A new division never starts while one is running
   a_div_go_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |-> !div_busy)
      else $error("divider started while busy");

   // A miss always leaves a zero word
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> (word_ff == '0))
      else $error("timing word not cleared on miss");

endmodule

// ----- rtl/core/cbt_ctrl.sv -----
// Controller state machine sequencing divisions and the quanta scan.
module cbt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   output cbt_pkg::cbt_cmd_type     cmd,
   input  cbt_pkg::cbt_status_type  status
);
   import cbt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHK_D,
      ST_WAIT_W,
      ST_CHK_W,
      ST_GO_Q,
      ST_WAIT_Q,
      ST_EVAL,
      ST_FAIL
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      cmd.div_sel = DSEL_DENOM;
      state_in = state_ff;
      valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHK_D;
         end
         ST_CHK_D: begin
            if (status.denom_zero) begin
               state_in = ST_FAIL;
            end else begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = DSEL_DENOM;
               state_in    = ST_WAIT_W;
            end
         end
         ST_WAIT_W: begin
            if (status.div_done) begin
               cmd.cap_w = 1'b1;
               state_in  = ST_CHK_W;
            end
         end
         ST_CHK_W: begin
            if (status.w_zero) begin
               state_in = ST_FAIL;
            end else begin
               cmd.q_init = 1'b1;
               state_in   = ST_GO_Q;
            end
         end
         ST_GO_Q: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DSEL_Q;
            state_in    = ST_WAIT_Q;
         end
         ST_WAIT_Q: begin
            if (status.div_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.hit) begin
               cmd.set_hit = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.q_last) begin
               state_in = ST_FAIL;
            end else begin
               cmd.q_dec = 1'b1;
               state_in  = ST_GO_Q;
            end
         end
         ST_FAIL: begin
            cmd.set_miss = 1'b1;
            valid_in     = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   // An accepted word makes the block busy on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start a search");

   // The result strobe lasts exactly one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff)
      else $error("result strobe longer than one cycle");

endmodule

// ----- rtl/core/can_bit_timing_calculator.sv -----
// Top level of the CAN bit timing calculator: controller, datapath and ports.
//
// Usage: write system clock (index 0), peripheral divisor (1) and sync jump
// width (2) through the csr_ port while the block is idle. Raise start with a
// requested bit rate on req_bit_rate_hz; the word is taken at the clock edge
// where start is high and busy is low. busy stays high until the result.
// The result appears on rsp_found and rsp_timing_word, marked by rsp_valid for
// exactly one cycle; the receiver cannot stall it, so it must be taken then.
// The search runs one bit-serial division for the clock ratio, then one
// division per candidate quanta count from 24 down to 3; the prescaler bounds
// are checked by small constant products. A zero divisor or a zero ratio ends
// the search in a miss without the scan. A new word may be started in the
// cycle the result shows.
// Synchronous reset restores the configuration defaults (96 MHz, divisor 1,
// SJW 1), returns the controller to idle and drops any search in flight.
module can_bit_timing_calculator #(
   parameter int MAX_BITS_PER_BIT_TIME = cbt_pkg::MAX_BITS_PER_BIT_TIME_DEF,
   parameter int MIN_BITS_PER_BIT_TIME = cbt_pkg::MIN_BITS_PER_BIT_TIME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [cbt_pkg::IDX_CSR_W-1:0]   csr_index,
   input  logic [cbt_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            start,
   output logic                            busy,
   input  logic [cbt_pkg::RATE_W-1:0]      req_bit_rate_hz,
   output logic                            rsp_valid,
   output logic                            rsp_found,
   output logic [cbt_pkg::WORD_W-1:0]      rsp_timing_word
);
   import cbt_pkg::*;

   cbt_cmd_type    cmd;
   cbt_status_type status;

   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   cbt_datapath #(
      .MAX_BITS_PER_BIT_TIME (MAX_BITS_PER_BIT_TIME),
      .MIN_BITS_PER_BIT_TIME (MIN_BITS_PER_BIT_TIME)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bit_rate_hz  (req_bit_rate_hz),
      .cmd              (cmd),
      .status           (status),
      .rsp_found        (rsp_found),
      .rsp_timing_word  (rsp_timing_word)
   );

endmodule
